>>> sv/s2da_pkg.sv
// Package for the signed integer to decimal ASCII converter.
// Holds the state and cell operation types and the ASCII constants.
// No dependencies.
`default_nettype none

package s2da_pkg;

    // BCD digit width held by one cell
    localparam int DIGIT_W = 4;

    // ASCII codes
    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_MINUS = 8'd45;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } t_state;

    // Operation applied to every cell of the chain in one cycle
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_CLEAR,
        OP_DABBLE,
        OP_SHIFT
    } t_cell_op;

endpackage

`default_nettype wire

>>> sv/signed_int_to_decimal_ascii_top.sv
// Top level of the signed integer to decimal ASCII converter.
// Controller, magnitude shifter and a chain of s2da_bcd_cell digit cells.
// Depends on s2da_pkg and s2da_bcd_cell.
// Sequence: a request taken while idle gives its minus sign (if negative) in the
// next cycle; busy stays high through VALUE_WIDTH double-dabble steps through the
// cell chain, then one digit slot per cell. Last digit is strobed as busy falls;
// a new request is taken only once idle again; no stall.
// Reset (synchronous, active low) returns to idle with no strobe pending.
`default_nettype none

module signed_int_to_decimal_ascii_top #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    start,
    output logic                   busy,
    input  wire  [VALUE_WIDTH-1:0] i_value,
    output logic                   o_valid,
    output logic [7:0]             o_character,
    output logic                   o_last
);

    // decimal digits of 2^(VALUE_WIDTH-1)
    localparam int NDIG   = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
    localparam int CNT_W  = $clog2(VALUE_WIDTH + 1);
    localparam int DCNT_W = $clog2(NDIG + 1);
    localparam int DW     = s2da_pkg::DIGIT_W;

    s2da_pkg::t_state   r_state, n_state;
    s2da_pkg::t_cell_op w_op;

    logic [VALUE_WIDTH-1:0] r_mag, n_mag;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic [DCNT_W-1:0]      r_dcnt, n_dcnt;
    logic                   r_started, n_started;
    logic                   r_valid, n_valid;
    logic [7:0]             r_char, n_char;
    logic                   r_last, n_last;

    logic [DW-1:0]          w_digit [NDIG+1];
    logic                   w_bit   [NDIG+1];
    logic                   w_neg;
    logic [VALUE_WIDTH-1:0] w_abs;
    logic [DW-1:0]          w_top;
    logic                   w_final;

    // magnitude as unsigned, most negative value stays exact
    assign w_neg = i_value[VALUE_WIDTH-1];
    assign w_abs = w_neg ? (~i_value + VALUE_WIDTH'(1)) : i_value;

    // cell chain: bits and digits move from cell 0 upward
    assign w_digit[0] = '0;
    assign w_bit[0]   = r_mag[VALUE_WIDTH-1];

    for (genvar g = 0; g < NDIG; g++) begin : g_cell
        s2da_bcd_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_op    (w_op),
            .i_bit   (w_bit[g]),
            .i_digit (w_digit[g]),
            .o_digit (w_digit[g+1]),
            .o_bit   (w_bit[g+1])
        );
    end

    assign w_top   = w_digit[NDIG];
    assign w_final = (r_dcnt == DCNT_W'(1));

    // next state and outputs
    always_comb begin
        n_state   = r_state;
        n_mag     = r_mag;
        n_cnt     = r_cnt;
        n_dcnt    = r_dcnt;
        n_started = r_started;
        n_valid   = 1'b0;
        n_char    = r_char;
        n_last    = 1'b0;
        w_op      = s2da_pkg::OP_HOLD;
        unique case (r_state)
            s2da_pkg::ST_IDLE: begin
                if (start) begin
                    n_state   = s2da_pkg::ST_CONV;
                    n_mag     = w_abs;
                    n_cnt     = CNT_W'(VALUE_WIDTH);
                    n_started = 1'b0;
                    w_op      = s2da_pkg::OP_CLEAR;
                    // minus sign goes out right away
                    n_valid   = w_neg;
                    n_char    = s2da_pkg::CHAR_MINUS;
                end
            end
            s2da_pkg::ST_CONV: begin
                w_op  = s2da_pkg::OP_DABBLE;
                n_mag = {r_mag[VALUE_WIDTH-2:0], 1'b0};
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    n_state = s2da_pkg::ST_EMIT;
                    n_dcnt  = DCNT_W'(NDIG);
                end
            end
            s2da_pkg::ST_EMIT: begin
                w_op   = s2da_pkg::OP_SHIFT;
                n_dcnt = r_dcnt - DCNT_W'(1);
                // skip leading zeros, but always give the ones digit
                if (w_top != '0 || r_started || w_final) begin
                    n_valid   = 1'b1;
                    n_started = 1'b1;
                    n_char    = s2da_pkg::CHAR_ZERO + {4'b0000, w_top};
                    n_last    = w_final;
                end
                if (w_final) begin
                    n_state = s2da_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = s2da_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= s2da_pkg::ST_IDLE;
            r_cnt     <= '0;
            r_dcnt    <= '0;
            r_started <= 1'b0;
            r_valid   <= 1'b0;
            r_last    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_dcnt    <= n_dcnt;
            r_started <= n_started;
            r_valid   <= n_valid;
            r_last    <= n_last;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_mag  <= n_mag;
        r_char <= n_char;
    end

    assign busy        = (r_state != s2da_pkg::ST_IDLE);
    assign o_valid     = r_valid;
    assign o_character = r_char;
    assign o_last      = r_last;

    // the top cell never carries out during conversion
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == s2da_pkg::ST_CONV |-> !w_bit[NDIG])
        else $error("digit chain overflow");

    // a taken request makes the block busy
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after request");

    // emission always ends with a flagged last character
    a_emit_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == s2da_pkg::ST_EMIT && w_final |=> o_valid && o_last)
        else $error("final digit not flagged");

    // digit counter never runs out while emitting
    a_dcnt_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == s2da_pkg::ST_EMIT |-> r_dcnt != '0)
        else $error("digit counter underflow");

    // conversion leads only to more conversion or emission
    a_conv_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == s2da_pkg::ST_CONV |=>
            (r_state == s2da_pkg::ST_CONV || r_state == s2da_pkg::ST_EMIT))
        else $error("bad exit from conversion");

endmodule

`default_nettype wire

>>> sv/s2da_bcd_cell.sv
// One BCD digit cell of the double-dabble chain.
// Adjusts and shifts one bit per cycle while dabbling, passes whole digits toward the top, or clears or holds.
// Depends on s2da_pkg.
`default_nettype none

module s2da_bcd_cell (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  s2da_pkg::t_cell_op                   i_op,
    input  wire                                  i_bit,
    input  wire  [s2da_pkg::DIGIT_W-1:0]         i_digit,
    output logic [s2da_pkg::DIGIT_W-1:0]         o_digit,
    output logic                                 o_bit
);

    logic [s2da_pkg::DIGIT_W-1:0] r_digit;
    logic [s2da_pkg::DIGIT_W-1:0] n_digit;
    logic [s2da_pkg::DIGIT_W-1:0] w_adj;

    // add 3 when the digit would exceed 9 after doubling
    assign w_adj = (r_digit >= s2da_pkg::DIGIT_W'(5)) ?
                   r_digit + s2da_pkg::DIGIT_W'(3) : r_digit;

    always_comb begin
        case (i_op)
            s2da_pkg::OP_CLEAR:  n_digit = '0;
            s2da_pkg::OP_DABBLE: n_digit = {w_adj[s2da_pkg::DIGIT_W-2:0], i_bit};
            s2da_pkg::OP_SHIFT:  n_digit = i_digit;
            default:             n_digit = r_digit;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit <= '0;
        end else begin
            r_digit <= n_digit;
        end
    end

    assign o_digit = r_digit;
    assign o_bit   = w_adj[s2da_pkg::DIGIT_W-1];

endmodule

`default_nettype wire
